[hdl/mbsp_pkg.sv]
// ----------------------------------------------------------------------------
// mbsp_pkg
// Shared types and byte codes for the MIDI byte stream parser.
// ----------------------------------------------------------------------------
package mbsp_pkg;

	localparam logic [7:0] SYSEX_START   = 8'hF0;
	localparam logic [7:0] SYSEX_END     = 8'hF7;
	localparam logic [7:0] REALTIME_BASE = 8'hF8;
	localparam logic [7:0] NO_STATUS     = 8'h00;
	localparam logic [3:0] KIND_SYSTEM   = 4'hF;
	localparam logic [3:0] KIND_PROGRAM  = 4'hC;
	localparam logic [3:0] KIND_PRESSURE = 4'hD;

	typedef struct packed {
		logic [7:0] running_status;
		logic [6:0] first_data;
		logic       have_first;
		logic       inside_sysex;
	} parse_state_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] msg_status;
		logic [6:0] msg_data1;
		logic [6:0] msg_data2;
	} parse_result_t;

endpackage

[hdl/midi_byte_stream_parser_core.sv]
// Output: a message leaves on out_valid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; the decode is one combinational pass into
// the output register; in_ready drops only while a message waits and out_ready is low.
// Reset (arst_n low, asynchronous): no running status, not in sysex,
// no held data byte, output empty, emit_enable set.
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_core
// MIDI 1.0 byte stream to channel message parser with running status.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       emit_enable_we,
	input  logic       emit_enable_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] msg_status,
	output logic [6:0] msg_data1,
	output logic [6:0] msg_data2
);
	import mbsp_pkg::*;

	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t res;
	logic          emit_enable_q;
	logic          out_valid_q;
	logic [7:0]    msg_status_q;
	logic [6:0]    msg_data1_q;
	logic [6:0]    msg_data2_q;
	logic          in_beat;

	assign in_ready = !out_valid_q || out_ready;
	assign in_beat  = in_valid && in_ready;

	mbsp_decoder u_decoder (
		.data_byte   (data_byte),
		.emit_enable (emit_enable_q),
		.cur         (state_q),
		.nxt         (state_nxt),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= '0;
			emit_enable_q <= 1'b1;
			out_valid_q   <= 1'b0;
		end else begin
			if (emit_enable_we) begin
				emit_enable_q <= emit_enable_wdata;
			end
			if (in_beat) begin
				state_q     <= state_nxt;
				out_valid_q <= res.emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && res.emit) begin
			msg_status_q <= res.msg_status;
			msg_data1_q  <= res.msg_data1;
			msg_data2_q  <= res.msg_data2;
		end
	end

	assign out_valid  = out_valid_q;
	assign msg_status = msg_status_q;
	assign msg_data1  = msg_data1_q;
	assign msg_data2  = msg_data2_q;

`ifndef SYNTHESIS
	a_status_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (msg_status_q[7] && msg_status_q[7:4] != KIND_SYSTEM))
		else $error("emitted status is not a channel status");

	a_one_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (msg_status_q[7:4] == KIND_PROGRAM ||
		msg_status_q[7:4] == KIND_PRESSURE)) |-> (msg_data2_q == 7'd0))
		else $error("one-data-byte message with nonzero data2");

	a_running_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.running_status == NO_STATUS) ||
		(state_q.running_status[7] && state_q.running_status[7:4] != KIND_SYSTEM))
		else $error("running status holds an illegal value");

	a_beat_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_beat))
		else $error("output beat without an accepted input beat");

	a_no_emit_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && !emit_enable_q) |=> !out_valid_q)
		else $error("message emitted while emit is disabled");
`endif

endmodule

[hdl/mbsp_decoder.sv]
// ----------------------------------------------------------------------------
// mbsp_decoder
// Next-state and message logic for one MIDI byte.
// ----------------------------------------------------------------------------
module mbsp_decoder (
	input  logic [7:0]             data_byte,
	input  logic                   emit_enable,
	input  mbsp_pkg::parse_state_t cur,
	output mbsp_pkg::parse_state_t nxt,
	output mbsp_pkg::parse_result_t res
);
	import mbsp_pkg::*;

	logic one_byte;

	assign one_byte = (cur.running_status[7:4] == KIND_PROGRAM) ||
		(cur.running_status[7:4] == KIND_PRESSURE);

	always_comb begin
		nxt            = cur;
		res.emit       = 1'b0;
		res.msg_status = cur.running_status;
		res.msg_data1  = data_byte[6:0];
		res.msg_data2  = 7'd0;
		priority if (data_byte >= REALTIME_BASE) begin
			nxt = cur;
		end else if (data_byte == SYSEX_START) begin
			nxt.inside_sysex = 1'b1;
		end else if (data_byte == SYSEX_END) begin
			nxt.inside_sysex = 1'b0;
		end else if (cur.inside_sysex) begin
			nxt = cur;
		end else if (data_byte[7]) begin
			if (data_byte[7:4] == KIND_SYSTEM) begin
				nxt.running_status = NO_STATUS;
			end else begin
				nxt.running_status = data_byte;
				nxt.have_first     = 1'b0;
			end
		end else if (cur.running_status == NO_STATUS) begin
			nxt = cur;
		end else if (!cur.have_first) begin
			nxt.first_data = data_byte[6:0];
			if (one_byte) begin
				res.emit = emit_enable;
			end else begin
				nxt.have_first = 1'b1;
			end
		end else begin
			nxt.have_first = 1'b0;
			res.emit       = emit_enable;
			res.msg_data1  = cur.first_data;
			res.msg_data2  = data_byte[6:0];
		end
	end

endmodule
